>>> rtl/olst_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list store package
// Word formats, operation codes, status codes and cell commands shared by the
// ordered list store controller, its cells and the top level.
// ----------------------------------------------------------------------------
package olst_pkg;

    localparam int CAPACITY   = 64;
    localparam int ITEM_BITS  = 6;
    localparam int KIND_BITS  = 4;
    localparam int POS_BITS   = 7;
    localparam int STAT_BITS  = 2;
    localparam int COUNT_BITS = 7;

    // Index and count fields of the cell command cover the largest list.
    localparam int IDX_BITS = 10;
    localparam int CNT_BITS = 11;

    localparam logic [KIND_BITS-1:0] KIND_INS_HEAD = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_INS_TAIL = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_INS_IDX  = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_REPLACE  = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_READ     = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_FIND     = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_RM_VALUE = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_RM_HEAD  = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_RM_TAIL  = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_RM_IDX   = 4'd9;

    localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd3;

    localparam int CELL_OP_BITS = 3;
    localparam logic [CELL_OP_BITS-1:0] CELL_HOLD       = 3'd0;
    localparam logic [CELL_OP_BITS-1:0] CELL_INSERT     = 3'd1;
    localparam logic [CELL_OP_BITS-1:0] CELL_REPLACE    = 3'd2;
    localparam logic [CELL_OP_BITS-1:0] CELL_REMOVE     = 3'd3;
    localparam logic [CELL_OP_BITS-1:0] CELL_SHIFT_HIT  = 3'd4;
    localparam logic [CELL_OP_BITS-1:0] CELL_SCAN_START = 3'd5;
    localparam logic [CELL_OP_BITS-1:0] CELL_SCAN_STEP  = 3'd6;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [ITEM_BITS-1:0] item;
        logic [POS_BITS-1:0]  position;
    } in_word_t;

    typedef struct packed {
        logic [STAT_BITS-1:0]  status;
        logic [ITEM_BITS-1:0]  item_out;
        logic                  found;
        logic [COUNT_BITS-1:0] count;
    } out_word_t;

    typedef struct packed {
        logic [CELL_OP_BITS-1:0] op;
        logic [IDX_BITS-1:0]     at;
        logic [ITEM_BITS-1:0]    item;
        logic [CNT_BITS-1:0]     count;
    } cell_cmd_t;

endpackage

>>> rtl/ordered_list_store_unit.sv
// ----------------------------------------------------------------------------
// Ordered list store unit
// An ordered list of item codes held in a row of cells, with inserts,
// replacements, reads, finds and removals that shift later entries.
//
//   channel   ports              word         direction
//   input     s_valid s_ready    s_data       operation word in
//   result    m_valid m_ready    m_data       result word out
//
// Insert, replace and a rejected operation go from idle straight to the
// finish state, where the result word is registered once the output register
// is free. Read, find and the removals first scan the row of cells one cell
// per cycle in the start and step states.
// One operation is in flight at a time; the next word is taken while the
// result waits in the output register.
// A stalled result word holds the cell row untouched until it is taken.
// Reset clears the count and the handshake state; entries are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_store_unit #(
    parameter int CAPACITY = olst_pkg::CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  olst_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output olst_pkg::out_word_t m_data
);
    import olst_pkg::*;

    cell_cmd_t            cmd;
    logic [ITEM_BITS-1:0] data_w [CAPACITY];
    logic                 seen_w [CAPACITY];
    logic                 any_w  [CAPACITY];
    logic [ITEM_BITS-1:0] col_w  [CAPACITY];

    olst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd_o   (cmd),
        .any_i   (any_w[0]),
        .col_i   (col_w[0])
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ITEM_BITS-1:0] lo, hi, col_in;
        logic                 seen_in, any_in;

        if (i == 0) begin : g_first
            assign lo      = '0;
            assign seen_in = 1'b0;
        end else begin : g_inner_lo
            assign lo      = data_w[i-1];
            assign seen_in = seen_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign hi     = data_w[i];
            assign any_in = 1'b0;
            assign col_in = '0;
        end else begin : g_inner_hi
            assign hi     = data_w[i+1];
            assign any_in = any_w[i+1];
            assign col_in = col_w[i+1];
        end

        olst_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd_i     (cmd),
            .data_lo_i (lo),
            .data_hi_i (hi),
            .seen_i    (seen_in),
            .any_i     (any_in),
            .col_i     (col_in),
            .data_o    (data_w[i]),
            .seen_o    (seen_w[i]),
            .any_o     (any_w[i]),
            .col_o     (col_w[i])
        );
    end

endmodule

>>> rtl/olst_cell.sv
// ----------------------------------------------------------------------------
// Ordered list store cell
// Holds one list entry, shifts it to or from its neighbors, and carries the
// scan chains that find the first match and bring a selected entry to cell 0.
// ----------------------------------------------------------------------------
module olst_cell #(
    parameter int INDEX = 0
) (
    input  logic                           aclk,
    input  olst_pkg::cell_cmd_t            cmd_i,
    input  logic [olst_pkg::ITEM_BITS-1:0] data_lo_i,
    input  logic [olst_pkg::ITEM_BITS-1:0] data_hi_i,
    input  logic                           seen_i,
    input  logic                           any_i,
    input  logic [olst_pkg::ITEM_BITS-1:0] col_i,
    output logic [olst_pkg::ITEM_BITS-1:0] data_o,
    output logic                           seen_o,
    output logic                           any_o,
    output logic [olst_pkg::ITEM_BITS-1:0] col_o
);
    import olst_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(INDEX);
    localparam logic [CNT_BITS-1:0] MY_POS = CNT_BITS'(INDEX);

    logic [ITEM_BITS-1:0] data_reg;
    logic                 hit_reg;
    logic                 seen_reg;
    logic                 any_reg;
    logic [ITEM_BITS-1:0] col_reg;
    logic                 hit_now;

    assign hit_now = (MY_POS < cmd_i.count) && (data_reg == cmd_i.item);

    always_ff @(posedge aclk) begin
        case (cmd_i.op)
            CELL_INSERT: begin
                if (MY_IDX > cmd_i.at) begin
                    data_reg <= data_lo_i;
                end else if (MY_IDX == cmd_i.at) begin
                    data_reg <= cmd_i.item;
                end
            end
            CELL_REPLACE: begin
                if (MY_IDX == cmd_i.at) begin
                    data_reg <= cmd_i.item;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= cmd_i.at) begin
                    data_reg <= data_hi_i;
                end
            end
            CELL_SHIFT_HIT: begin
                if (seen_reg || hit_reg) begin
                    data_reg <= data_hi_i;
                end
            end
            CELL_SCAN_START: begin
                hit_reg  <= hit_now;
                any_reg  <= hit_now;
                seen_reg <= 1'b0;
                col_reg  <= (MY_IDX == cmd_i.at) ? data_reg : '0;
            end
            CELL_SCAN_STEP: begin
                seen_reg <= seen_i;
                any_reg  <= any_reg | any_i;
                col_reg  <= col_reg | col_i;
            end
            default: begin
            end
        endcase
    end

    assign data_o = data_reg;
    assign seen_o = seen_reg | hit_reg;
    assign any_o  = any_reg;
    assign col_o  = col_reg;

endmodule

>>> rtl/olst_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered list store controller
// Checks each operation against the count, sequences the scan and the update
// of the cell row, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module olst_ctrl #(
    parameter int CAPACITY = olst_pkg::CAPACITY
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  olst_pkg::in_word_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output olst_pkg::out_word_t            m_data,
    output olst_pkg::cell_cmd_t            cmd_o,
    input  logic                           any_i,
    input  logic [olst_pkg::ITEM_BITS-1:0] col_i
);
    import olst_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_BITS-1:0] CAP_X = CNT_BITS'(CAPACITY);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_STEP   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        steps_reg;
    logic [CELL_OP_BITS-1:0] act_reg;
    logic [IDX_BITS-1:0]     at_reg;
    logic [ITEM_BITS-1:0]    item_reg;
    logic [STAT_BITS-1:0]    status_reg;
    logic                    rd_reg, fd_reg, rv_reg, inc_reg, dec_reg;
    logic                    m_valid_reg;
    out_word_t               m_data_reg;

    logic                    accept, out_free, load_out;
    logic [CNT_BITS-1:0]     pos_x, cnt_x, cnt_m1, cnt_new_x;
    logic [STAT_BITS-1:0]    d_status;
    logic [CELL_OP_BITS-1:0] d_act;
    logic [IDX_BITS-1:0]     d_at;
    logic                    d_scan, d_rd, d_fd, d_rv, d_inc, d_dec;
    logic                    rv_hit;
    out_word_t               res;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == S_FINISH) && out_free;
    assign s_ready  = (state_reg == S_IDLE);

    assign pos_x  = CNT_BITS'(s_data.position);
    assign cnt_x  = CNT_BITS'(count_reg);
    assign cnt_m1 = cnt_x - CNT_BITS'(1);

    always_comb begin
        d_status = ST_OK;
        d_act    = CELL_HOLD;
        d_at     = pos_x[IDX_BITS-1:0];
        d_scan   = 1'b0;
        d_rd     = 1'b0;
        d_fd     = 1'b0;
        d_rv     = 1'b0;
        d_inc    = 1'b0;
        d_dec    = 1'b0;
        case (s_data.kind)
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_IDX: begin
                if (cnt_x >= CAP_X) begin
                    d_status = ST_FULL;
                end else if (s_data.kind == KIND_INS_IDX && pos_x > cnt_x) begin
                    d_status = ST_RANGE;
                end else begin
                    d_act = CELL_INSERT;
                    d_inc = 1'b1;
                    if (s_data.kind == KIND_INS_HEAD) begin
                        d_at = '0;
                    end else if (s_data.kind == KIND_INS_TAIL) begin
                        d_at = cnt_x[IDX_BITS-1:0];
                    end
                end
            end
            KIND_REPLACE: begin
                if (pos_x >= cnt_x) begin
                    d_status = ST_RANGE;
                end else begin
                    d_act = CELL_REPLACE;
                end
            end
            KIND_READ: begin
                if (pos_x >= cnt_x) begin
                    d_status = ST_RANGE;
                end else begin
                    d_scan = 1'b1;
                    d_rd   = 1'b1;
                end
            end
            KIND_FIND: begin
                d_scan = 1'b1;
                d_fd   = 1'b1;
            end
            KIND_RM_VALUE: begin
                d_scan = 1'b1;
                d_fd   = 1'b1;
                d_rv   = 1'b1;
                d_act  = CELL_SHIFT_HIT;
            end
            KIND_RM_HEAD, KIND_RM_TAIL, KIND_RM_IDX: begin
                if (cnt_x == '0) begin
                    d_status = ST_EMPTY;
                end else if (s_data.kind == KIND_RM_IDX && pos_x >= cnt_x) begin
                    d_status = ST_RANGE;
                end else begin
                    d_scan = 1'b1;
                    d_rd   = 1'b1;
                    d_act  = CELL_REMOVE;
                    d_dec  = 1'b1;
                    if (s_data.kind == KIND_RM_HEAD) begin
                        d_at = '0;
                    end else if (s_data.kind == KIND_RM_TAIL) begin
                        d_at = cnt_m1[IDX_BITS-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign rv_hit     = rv_reg && any_i;
    assign count_next = load_out
        ? count_reg + CNT_W'(inc_reg) - CNT_W'(dec_reg) - CNT_W'(rv_hit)
        : count_reg;
    assign cnt_new_x  = CNT_BITS'(count_next);

    always_comb begin
        res.status   = status_reg;
        res.item_out = rd_reg ? col_i : (rv_hit ? item_reg : '0);
        res.found    = fd_reg && any_i;
        res.count    = cnt_new_x[COUNT_BITS-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = d_scan ? S_START : S_FINISH;
                end
            end
            S_START: begin
                state_next = (count_reg <= CNT_W'(1)) ? S_FINISH : S_STEP;
            end
            S_STEP: begin
                if (steps_reg <= CNT_W'(1)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd_o.op    = CELL_HOLD;
        cmd_o.at    = at_reg;
        cmd_o.item  = item_reg;
        cmd_o.count = cnt_x;
        case (state_reg)
            S_START:  cmd_o.op = CELL_SCAN_START;
            S_STEP:   cmd_o.op = CELL_SCAN_STEP;
            S_FINISH: cmd_o.op = out_free ? act_reg : CELL_HOLD;
            default:  cmd_o.op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= d_status;
            act_reg    <= d_act;
            at_reg     <= d_at;
            item_reg   <= s_data.item;
            rd_reg     <= d_rd;
            fd_reg     <= d_fd;
            rv_reg     <= d_rv;
            inc_reg    <= d_inc;
            dec_reg    <= d_dec;
        end
        if (state_reg == S_START) begin
            steps_reg <= count_reg - CNT_W'(1);
        end else if (state_reg == S_STEP) begin
            steps_reg <= steps_reg - CNT_W'(1);
        end
        if (load_out) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && !out_free) |-> cmd_o.op == CELL_HOLD)
        else $error("cell row updated while the result word is blocked");

    a_count_only_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !load_out |=> $stable(count_reg))
        else $error("count changed without a result word");

    a_scan_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_START) |-> status_reg == ST_OK)
        else $error("scan started for a rejected operation");

endmodule

>>> tb/olst_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list store result checker
// Watches the operation and result channels of the ordered list store. Every
// accepted operation word is applied to a private copy of the list to
// predict its result word. Every accepted result word is compared field by
// field with the oldest prediction. The number of failures and the number of
// predictions still waiting are handed to the testbench top.
// ----------------------------------------------------------------------------
module olst_result_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  olst_pkg::in_word_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  olst_pkg::out_word_t m_data,
    output int                  fail_count,
    output int                  words_pending
);
    import olst_pkg::*;

    logic [ITEM_BITS-1:0]  list_entries [CAPACITY];
    logic [COUNT_BITS-1:0] list_len;
    out_word_t             expected_words [$];

    function automatic out_word_t apply_list_op(input in_word_t w);
        out_word_t r;
        int        at;
        int        i;
        bit        do_insert;
        bit        do_remove;
        r         = '0;
        at        = 0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        case (w.kind)
            KIND_INS_HEAD, KIND_INS_TAIL, KIND_INS_IDX: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (w.kind == KIND_INS_HEAD) begin
                    do_insert = 1'b1;
                end else if (w.kind == KIND_INS_TAIL) begin
                    at        = int'(list_len);
                    do_insert = 1'b1;
                end else if (w.position > list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    at        = int'(w.position);
                    do_insert = 1'b1;
                end
            end
            KIND_REPLACE: begin
                if (w.position >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    list_entries[w.position] = w.item;
                end
            end
            KIND_READ: begin
                if (w.position >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.item_out = list_entries[w.position];
                end
            end
            KIND_FIND, KIND_RM_VALUE: begin
                // Scanning from the tail leaves the first match in at.
                for (i = int'(list_len) - 1; i >= 0; i--) begin
                    if (list_entries[i] == w.item) begin
                        r.found = 1'b1;
                        at      = i;
                    end
                end
                do_remove = r.found && (w.kind == KIND_RM_VALUE);
            end
            KIND_RM_HEAD, KIND_RM_TAIL, KIND_RM_IDX: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (w.kind == KIND_RM_HEAD) begin
                    do_remove = 1'b1;
                end else if (w.kind == KIND_RM_TAIL) begin
                    at        = int'(list_len) - 1;
                    do_remove = 1'b1;
                end else if (w.position >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    at        = int'(w.position);
                    do_remove = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (do_insert) begin
            for (i = int'(list_len); i > at; i--) begin
                list_entries[i] = list_entries[i-1];
            end
            list_entries[at] = w.item;
            list_len++;
        end
        if (do_remove) begin
            r.item_out = list_entries[at];
            for (i = at; i + 1 < int'(list_len); i++) begin
                list_entries[i] = list_entries[i+1];
            end
            list_len--;
        end
        r.count = list_len;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            list_len = '0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected result word: ", $realtime,
                                 "status %0d item %0d found %0d count %0d",
                                 m_data.status, m_data.item_out, m_data.found,
                                 m_data.count);
                    end
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.status !== want.status || m_data.item_out !== want.item_out ||
                        m_data.found !== want.found || m_data.count !== want.count) begin
                        if (fail_count < 10) begin
                            $display("%0t: result mismatch: ", $realtime,
                                     "expected status %0d item %0d found %0d count %0d, ",
                                     want.status, want.item_out, want.found, want.count,
                                     "got status %0d item %0d found %0d count %0d",
                                     m_data.status, m_data.item_out, m_data.found,
                                     m_data.count);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_words.push_back(apply_list_op(s_data));
            end
        end
        words_pending = expected_words.size();
    end

endmodule

>>> tb/tb_ordered_list_store_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered list store unit testbench
// Drives operation words into the ordered list store: a directed pass over
// the empty and bad-index cases and every operation, then random traffic
// that alternately fills and drains the list. Both channels idle at random
// in the first two of three phases. A separate checker predicts and compares
// the result words; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ordered_list_store_unit;
    import olst_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_NONE_FIRST = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_NONE_LAST  = 4'd15;
    localparam int                   RANDOM_WORDS    = 1830;
    localparam int                   BLOCK_WORDS     = 120;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;
    int        fail_count;
    int        words_pending;
    int        send_idle;
    int        recv_idle;

    ordered_list_store_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    olst_result_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= recv_idle);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input logic [KIND_BITS-1:0] kind,
                           input logic [ITEM_BITS-1:0] item,
                           input logic [POS_BITS-1:0]  position);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_data.kind     = kind;
        s_data.item     = item;
        s_data.position = position;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        int                   n;
        int                   pick;
        bit                   grow;
        logic [KIND_BITS-1:0] kind;
        logic [ITEM_BITS-1:0] item;
        logic [POS_BITS-1:0]  position;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        send_idle = 29;
        recv_idle = 51;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_op(KIND_RM_HEAD, 6'd0, 7'd0);
        send_op(KIND_RM_TAIL, 6'd63, 7'd0);
        send_op(KIND_RM_IDX, 6'd0, 7'd0);
        send_op(KIND_READ, 6'd0, 7'd0);
        send_op(KIND_REPLACE, 6'd63, 7'd0);
        send_op(KIND_FIND, 6'd0, 7'd0);
        send_op(KIND_RM_VALUE, 6'd63, 7'd0);
        send_op(KIND_INS_IDX, 6'd1, 7'd1);
        send_op(KIND_INS_IDX, 6'd63, 7'd0);
        send_op(KIND_INS_HEAD, 6'd0, 7'd64);
        send_op(KIND_INS_TAIL, 6'd42, 7'd0);
        send_op(KIND_INS_IDX, 6'd21, 7'd3);
        send_op(KIND_INS_IDX, 6'd5, 7'd1);
        send_op(KIND_READ, 6'd0, 7'd4);
        send_op(KIND_READ, 6'd0, 7'd64);
        send_op(KIND_REPLACE, 6'd63, 7'd0);
        send_op(KIND_FIND, 6'd63, 7'd0);
        send_op(KIND_RM_VALUE, 6'd63, 7'd0);
        send_op(KIND_RM_IDX, 6'd0, 7'd4);
        send_op(KIND_RM_IDX, 6'd0, 7'd1);
        send_op(KIND_RM_HEAD, 6'd0, 7'd0);
        send_op(KIND_RM_TAIL, 6'd0, 7'd0);
        send_op(KIND_NONE_FIRST, 6'd63, 7'd64);
        send_op(KIND_NONE_LAST, 6'd0, 7'd0);
        send_op(KIND_RM_IDX, 6'd0, 7'd0);

        // Blocks alternately favor inserts and removals so that the list
        // keeps running between empty and full.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 3) begin
                send_idle = 51;
                recv_idle = 29;
            end else if (n == 2 * RANDOM_WORDS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            grow = ((n / BLOCK_WORDS) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (pick == 99) begin
                kind = KIND_BITS'($urandom_range(KIND_NONE_FIRST, KIND_NONE_LAST));
            end else if (grow) begin
                kind = (pick < 80)
                     ? KIND_BITS'($urandom_range(KIND_INS_HEAD, KIND_INS_IDX))
                     : KIND_BITS'($urandom_range(KIND_REPLACE, KIND_RM_IDX));
            end else if (pick < 65) begin
                kind = KIND_BITS'($urandom_range(KIND_RM_HEAD, KIND_RM_IDX));
            end else if (pick < 75) begin
                kind = KIND_RM_VALUE;
            end else begin
                kind = KIND_BITS'($urandom_range(KIND_INS_HEAD, KIND_FIND));
            end
            item     = ($urandom_range(0, 1) == 0) ? ITEM_BITS'($urandom_range(0, 63))
                                                   : ITEM_BITS'($urandom_range(0, 7));
            position = ($urandom_range(0, 1) == 0) ? POS_BITS'($urandom_range(0, 64))
                                                   : POS_BITS'($urandom_range(0, 3));
            send_op(kind, item, position);
        end
        s_valid = 1'b0;

        while (words_pending != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
